[design/tfn_pkg.sv]
// shared types and widths for the triangle face normal core
`default_nettype none
package tfn_pkg;
  localparam int COORD_BITS       = 16;
  localparam int NORMAL_FRAC_BITS = 14;
  localparam int EDGE_W  = COORD_BITS + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = PROD_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W;
  localparam int K_W     = NORMAL_FRAC_BITS + 1;
  localparam int IDX_W   = $clog2(K_W);
  localparam int RW      = SQ_W + 2 * NORMAL_FRAC_BITS + 8;
  localparam int OUT_W   = 16;
  localparam int IN_W    = 9 * COORD_BITS;

  typedef struct packed {
    logic                 valid;
    logic                 neg;
    logic                 deg;
    logic signed [RW-1:0] r;
    logic signed [RW-1:0] p;
    logic [SUM_W-1:0]     s;
    logic [K_W-1:0]       k;
  } lane_t;
endpackage
`default_nettype wire

[design/tfn_cross.sv]
// edges, exact cross product, squared magnitudes and search seeds
`default_nettype none
module tfn_cross (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    advance,
  input  wire logic                    in_valid,
  input  wire logic [tfn_pkg::IN_W-1:0] in_data,
  output tfn_pkg::lane_t               lane_out [3]
);
  import tfn_pkg::*;

  logic signed [COORD_BITS-1:0] crd [9];
  logic signed [EDGE_W-1:0]  e1 [3];
  logic signed [EDGE_W-1:0]  e2 [3];
  logic signed [PROD_W-1:0]  prod [6];
  logic                      neg3 [3];
  logic [MAG_W-1:0]          mag3 [3];
  logic                      neg4 [3];
  logic [SQ_W-1:0]           sq4 [3];
  logic signed [CROSS_W-1:0] n_c [3];
  logic [SUM_W-1:0]          s_c;
  logic [4:1]                v;

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      crd[i] = in_data[i*COORD_BITS +: COORD_BITS];
    end
    n_c[0] = CROSS_W'(prod[0]) - CROSS_W'(prod[1]);
    n_c[1] = CROSS_W'(prod[2]) - CROSS_W'(prod[3]);
    n_c[2] = CROSS_W'(prod[4]) - CROSS_W'(prod[5]);
    s_c = sq4[0] + sq4[1] + sq4[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      for (int l = 0; l < 3; l++) begin
        lane_out[l].valid <= 1'b0;
      end
    end else if (advance) begin
      v <= {v[3:1], in_valid};
      for (int l = 0; l < 3; l++) begin
        lane_out[l].valid <= v[4];
      end
    end
    if (advance) begin
      for (int i = 0; i < 3; i++) begin
        e1[i] <= EDGE_W'(crd[3+i]) - EDGE_W'(crd[i]);
        e2[i] <= EDGE_W'(crd[6+i]) - EDGE_W'(crd[i]);
      end
      prod[0] <= e1[1] * e2[2];
      prod[1] <= e1[2] * e2[1];
      prod[2] <= e1[2] * e2[0];
      prod[3] <= e1[0] * e2[2];
      prod[4] <= e1[0] * e2[1];
      prod[5] <= e1[1] * e2[0];
      for (int i = 0; i < 3; i++) begin
        neg3[i] <= n_c[i][CROSS_W-1];
        mag3[i] <= n_c[i][CROSS_W-1] ? MAG_W'(-n_c[i]) : MAG_W'(n_c[i]);
        neg4[i] <= neg3[i];
        sq4[i]  <= mag3[i] * mag3[i];
      end
      for (int l = 0; l < 3; l++) begin
        // seed for t = -1: r = m^2 * 2^(2f+2) - s, p = -s
        lane_out[l].neg <= neg4[l];
        lane_out[l].deg <= (s_c == '0);
        lane_out[l].r   <= $signed(RW'(sq4[l]) << (2 * NORMAL_FRAC_BITS + 2))
                           - $signed(RW'(s_c));
        lane_out[l].p   <= -$signed(RW'(s_c));
        lane_out[l].s   <= s_c;
        lane_out[l].k   <= '0;
      end
    end
  end
endmodule
`default_nettype wire

[design/tfn_root_stage.sv]
// one bit of the rounded unit-magnitude search for one component
`default_nettype none
module tfn_root_stage (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      advance,
  input  wire logic [tfn_pkg::IDX_W-1:0] bit_idx,
  input  tfn_pkg::lane_t                 lane_in,
  output tfn_pkg::lane_t                 lane_out
);
  import tfn_pkg::*;

  logic [6:0]           sh_p;
  logic [6:0]           sh_s;
  logic signed [RW-1:0] tp;
  logic signed [RW-1:0] ts;
  logic signed [RW-1:0] rc;
  logic                 take;

  // candidate t' = t + 2^(j+1): r' = r - p*2^(j+2) - s*2^(2j+2)
  always_comb begin
    sh_p = 7'(bit_idx) + 7'd2;
    sh_s = 7'({bit_idx, 1'b0}) + 7'd2;
    tp   = lane_in.p <<< sh_p;
    ts   = $signed(RW'(lane_in.s) << sh_s);
    rc   = lane_in.r - tp - ts;
    take = !rc[RW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_out.valid <= 1'b0;
    end else if (advance) begin
      lane_out.valid <= lane_in.valid;
    end
    if (advance) begin
      lane_out.neg <= lane_in.neg;
      lane_out.deg <= lane_in.deg;
      lane_out.s   <= lane_in.s;
      if (take) begin
        lane_out.r <= rc;
        lane_out.p <= lane_in.p + $signed(RW'(lane_in.s) << (7'(bit_idx) + 7'd1));
        lane_out.k <= lane_in.k | (K_W'(1) << bit_idx);
      end else begin
        lane_out.r <= lane_in.r;
        lane_out.p <= lane_in.p;
        lane_out.k <= lane_in.k;
      end
    end
  end
endmodule
`default_nettype wire

[design/triangle_face_normal_core.sv]
// triangle face normal: cross product and exact rounded normalization
// throughput: one triangle per cycle; 5 cross/square stages, 15 search stages, 1 output
// the whole pipe stalls together while the output register holds an untaken result
// synchronous active-high reset clears all valid bits; no other state
`default_nettype none
module triangle_face_normal_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  wire logic [tfn_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [3*tfn_pkg::OUT_W-1:0]      m_axis_tdata,  // unit_x, unit_y, unit_z
  output logic                             m_axis_tuser   // degenerate
);
  import tfn_pkg::*;

  logic  advance;
  lane_t seed [3];
  lane_t stg [3][K_W+1];
  logic [OUT_W-1:0] uval [3];

  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = advance;

  tfn_cross u_cross (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .in_valid (s_axis_tvalid),
    .in_data  (s_axis_tdata),
    .lane_out (seed)
  );

  for (genvar l = 0; l < 3; l++) begin : g_lane
    assign stg[l][0] = seed[l];
    for (genvar i = 0; i < K_W; i++) begin : g_bit
      tfn_root_stage u_stage (
        .clk      (clk),
        .rst      (rst),
        .advance  (advance),
        .bit_idx  (IDX_W'(K_W - 1 - i)),
        .lane_in  (stg[l][i]),
        .lane_out (stg[l][i+1])
      );
    end
  end

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      uval[l] = stg[l][K_W].neg ? -OUT_W'(stg[l][K_W].k) : OUT_W'(stg[l][K_W].k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= stg[0][K_W].valid;
    end
    if (advance) begin
      m_axis_tuser <= stg[0][K_W].deg;
      for (int l = 0; l < 3; l++) begin
        m_axis_tdata[l*OUT_W +: OUT_W] <= stg[0][K_W].deg ? '0 : uval[l];
      end
    end
  end

  a_deg_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("degenerate result with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(m_axis_tdata[15:0]) <= 16384 &&
                       $signed(m_axis_tdata[15:0]) >= -16384 &&
                       $signed(m_axis_tdata[31:16]) <= 16384 &&
                       $signed(m_axis_tdata[31:16]) >= -16384 &&
                       $signed(m_axis_tdata[47:32]) <= 16384 &&
                       $signed(m_axis_tdata[47:32]) >= -16384))
    else $error("normal component out of range");

  a_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

  a_lanes: assert property (@(posedge clk) disable iff (rst)
    stg[0][K_W].valid == stg[1][K_W].valid && stg[0][K_W].valid == stg[2][K_W].valid)
    else $error("component lanes out of step");
endmodule
`default_nettype wire
